// File: hdl/zsbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zsbd_pkg: shared types and codes for the zlib stored-block decoder
// Holds the request payload types, the status codes and the parse phases.
// ----------------------------------------------------------------------------
package zsbd_pkg;

  // One request on the input channel.
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_item_t;

  // One request on the result channel.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        finished;
    logic [2:0]  status;
    logic [31:0] produced_length;
  } out_item_t;

  // Status codes reported with the final result.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HEADER    = 3'd1;
  localparam logic [2:0] ST_HUFFMAN   = 3'd2;
  localparam logic [2:0] ST_BADTYPE   = 3'd3;
  localparam logic [2:0] ST_LEN       = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;
  localparam logic [2:0] ST_CHECKSUM  = 3'd7;

  // Parse phases.
  localparam logic [3:0] PH_HDR0    = 4'd0;
  localparam logic [3:0] PH_HDR1    = 4'd1;
  localparam logic [3:0] PH_BLKHDR  = 4'd2;
  localparam logic [3:0] PH_LEN     = 4'd3;
  localparam logic [3:0] PH_DATA    = 4'd4;
  localparam logic [3:0] PH_TRAILER = 4'd5;
  localparam logic [3:0] PH_DONE    = 4'd6;

  // Stream constants.
  localparam logic [16:0] ADLER_MOD    = 17'd65521;
  localparam logic [3:0]  ZLIB_CM      = 4'd8;
  localparam logic [3:0]  ZLIB_CINFO   = 4'd7;
  localparam logic [1:0]  BTYPE_STORED = 2'd0;
  localparam logic [1:0]  BTYPE_BAD    = 2'd3;
  localparam logic [31:0] CAPACITY_RST = 32'hFFFF_FFFF;

endpackage : zsbd_pkg
`default_nettype wire

// File: hdl/zlib_stored_block_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zlib_stored_block_decoder: streaming zlib decoder for stored blocks only
// Checks the zlib header, parses stored deflate blocks, passes payload bytes
// out, keeps a running Adler-32 and compares it with the stream trailer.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle, sustained while the result
// side does not stall, and returns at most one result per byte: a payload
// byte, or the final report on the byte marked end_of_stream. A byte goes
// through an input register and then a result register, from which its
// result is presented; the per-byte path is one phase step and two
// modulo-65521 add and compare stages of the Adler-32 update. Bytes that
// cause no result are consumed silently. The result register accepts a new
// request while the consumer stalls only as long as it is empty, so a stall
// on the result side holds the input side after at most one more result.
// The capacity register may be written only while the block is idle; it is
// always ready.
module zlib_stored_block_decoder (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  zsbd_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output zsbd_pkg::out_item_t   out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [31:0]           cfg_data
);
  import zsbd_pkg::*;

  // Pipeline registers.
  in_item_t    in_q_r;
  logic        in_q_valid_r;
  out_item_t   out_q_r;
  logic        out_valid_r;
  logic [31:0] capacity_r;

  // Stream state.
  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  phase_count_r, phase_count_nxt;
  logic [7:0]  header_high_r, header_high_nxt;
  logic [15:0] stored_length_r, stored_length_nxt;
  logic [15:0] bytes_remaining_r, bytes_remaining_nxt;
  logic        final_block_r, final_block_nxt;
  logic [15:0] sum_low_r, sum_low_nxt;
  logic [15:0] sum_high_r, sum_high_nxt;
  logic [31:0] trailer_r, trailer_nxt;
  logic [31:0] produced_r, produced_nxt;
  logic [2:0]  fail_code_r, fail_code_nxt;
  logic        failed_r, failed_nxt;

  // Step signals.
  logic        advance;
  logic        emit;
  logic        has_result;
  out_item_t   result;
  logic [7:0]  b;
  logic [15:0] hdr;
  logic [6:0]  fold1;
  logic [5:0]  fold2;
  logic        hdr_mult31;
  logic [15:0] nlen;
  logic [32:0] need;
  logic [16:0] low_sum, high_sum;
  logic [15:0] low_mod, high_mod;
  logic [31:0] trailer_shift;
  logic [1:0]  btype;

  // Handshakes: the input register moves on when its request is processed.
  assign advance   = in_q_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_q_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;
  assign cfg_ready = 1'b1;

  // Header check: 2^5 is 1 modulo 31, so summing 5-bit digits keeps the residue.
  assign b     = in_q_r.stream_byte;
  assign hdr   = {header_high_r, b};
  assign fold1 = 7'(hdr[4:0]) + 7'(hdr[9:5]) + 7'(hdr[14:10]) + 7'(hdr[15]);
  assign fold2 = 6'(fold1[4:0]) + 6'(fold1[6:5]);
  assign hdr_mult31 = (fold2 == 6'd0) || (fold2 == 6'd31);

  // Stored length and capacity check.
  assign nlen = {b, header_high_r};
  assign need = {1'b0, produced_r} + 33'(stored_length_r);
  assign btype = b[2:1];

  // Adler-32 update, one conditional subtract per sum.
  assign low_sum  = 17'(sum_low_r) + 17'(b);
  assign low_mod  = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
  assign high_sum = 17'(sum_high_r) + 17'(low_mod);
  assign high_mod = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];

  assign trailer_shift = {trailer_r[23:0], b};

  // Phase step for the byte in the input register.
  always_comb begin
    phase_nxt           = phase_r;
    phase_count_nxt     = phase_count_r;
    header_high_nxt     = header_high_r;
    stored_length_nxt   = stored_length_r;
    bytes_remaining_nxt = bytes_remaining_r;
    final_block_nxt     = final_block_r;
    sum_low_nxt         = sum_low_r;
    sum_high_nxt        = sum_high_r;
    trailer_nxt         = trailer_r;
    produced_nxt        = produced_r;
    fail_code_nxt       = fail_code_r;
    failed_nxt          = failed_r;
    emit                = 1'b0;
    if (!failed_r) begin
      case (phase_r)
        PH_HDR0: begin
          header_high_nxt = b;
          phase_nxt       = PH_HDR1;
        end
        PH_HDR1: begin
          if (!hdr_mult31 || header_high_r[3:0] != ZLIB_CM ||
              header_high_r[7:4] != ZLIB_CINFO || b[5]) begin
            failed_nxt    = 1'b1;
            fail_code_nxt = ST_HEADER;
          end else begin
            phase_nxt = PH_BLKHDR;
          end
        end
        PH_BLKHDR: begin
          final_block_nxt = b[0];
          if (btype == BTYPE_STORED) begin
            phase_nxt       = PH_LEN;
            phase_count_nxt = 2'd0;
          end else if (btype == BTYPE_BAD) begin
            failed_nxt    = 1'b1;
            fail_code_nxt = ST_BADTYPE;
          end else begin
            failed_nxt    = 1'b1;
            fail_code_nxt = ST_HUFFMAN;
          end
        end
        PH_LEN: begin
          case (phase_count_r)
            2'd0: begin
              stored_length_nxt = {8'd0, b};
              phase_count_nxt   = 2'd1;
            end
            2'd1: begin
              stored_length_nxt = {b, stored_length_r[7:0]};
              phase_count_nxt   = 2'd2;
            end
            2'd2: begin
              header_high_nxt = b;
              phase_count_nxt = 2'd3;
            end
            default: begin
              // Last NLEN byte: complement check, then capacity check.
              if (stored_length_r != ~nlen) begin
                failed_nxt    = 1'b1;
                fail_code_nxt = ST_LEN;
              end else if (need > {1'b0, capacity_r}) begin
                failed_nxt    = 1'b1;
                fail_code_nxt = ST_OVERFLOW;
              end else begin
                bytes_remaining_nxt = stored_length_r;
                phase_count_nxt     = 2'd0;
                if (stored_length_r == 16'd0) begin
                  phase_nxt = final_block_r ? PH_TRAILER : PH_BLKHDR;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end
          endcase
        end
        PH_DATA: begin
          emit                = 1'b1;
          sum_low_nxt         = low_mod;
          sum_high_nxt        = high_mod;
          produced_nxt        = produced_r + 32'd1;
          bytes_remaining_nxt = bytes_remaining_r - 16'd1;
          if (bytes_remaining_r == 16'd1) begin
            phase_nxt       = final_block_r ? PH_TRAILER : PH_BLKHDR;
            phase_count_nxt = 2'd0;
          end
        end
        PH_TRAILER: begin
          trailer_nxt     = trailer_shift;
          phase_count_nxt = phase_count_r + 2'd1;
          if (phase_count_r == 2'd3) begin
            if (trailer_shift != {sum_high_r, sum_low_r}) begin
              failed_nxt    = 1'b1;
              fail_code_nxt = ST_CHECKSUM;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result for this byte.
  always_comb begin
    result.payload_byte    = emit ? b : 8'd0;
    result.payload_valid   = emit;
    result.finished        = in_q_r.end_of_stream;
    result.status          = ST_OK;
    result.produced_length = 32'd0;
    if (in_q_r.end_of_stream) begin
      if (failed_nxt) begin
        result.status = fail_code_nxt;
      end else if (phase_nxt != PH_DONE) begin
        result.status = ST_TRUNCATED;
      end else begin
        result.status = ST_OK;
      end
      result.produced_length = produced_nxt;
    end
  end

  assign has_result = emit || in_q_r.end_of_stream;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= has_result;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_q_r <= result;
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // Stream state: the end-of-stream byte returns everything to reset values.
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && in_q_r.end_of_stream)) begin
      phase_r           <= PH_HDR0;
      phase_count_r     <= 2'd0;
      header_high_r     <= 8'd0;
      stored_length_r   <= 16'd0;
      bytes_remaining_r <= 16'd0;
      final_block_r     <= 1'b0;
      sum_low_r         <= 16'd1;
      sum_high_r        <= 16'd0;
      trailer_r         <= 32'd0;
      produced_r        <= 32'd0;
      fail_code_r       <= ST_OK;
      failed_r          <= 1'b0;
    end else if (advance) begin
      phase_r           <= phase_nxt;
      phase_count_r     <= phase_count_nxt;
      header_high_r     <= header_high_nxt;
      stored_length_r   <= stored_length_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      final_block_r     <= final_block_nxt;
      sum_low_r         <= sum_low_nxt;
      sum_high_r        <= sum_high_nxt;
      trailer_r         <= trailer_nxt;
      produced_r        <= produced_nxt;
      fail_code_r       <= fail_code_nxt;
      failed_r          <= failed_nxt;
    end
  end

endmodule : zlib_stored_block_decoder
`default_nettype wire

// File: hdl/zsbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zsbd_checker: port-level checks for the zlib stored-block decoder
// Watches the result channel and the reset behavior of the top level.
// ----------------------------------------------------------------------------
module zsbd_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_stall,
  input zsbd_pkg::out_item_t  out_data
);
  import zsbd_pkg::*;

  // A stalled result request holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  // Every result carries a payload byte or the final report.
  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.payload_valid || out_data.finished)
    else $error("empty result request");

  // Status and length are zero except on the final report.
  a_out_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.finished |->
      out_data.status == ST_OK && out_data.produced_length == 32'd0)
    else $error("report fields set on a payload-only result");

  // A result without payload has a zero data byte.
  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
    else $error("data byte set without payload");

  // Reset empties the result register.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule : zsbd_checker

bind zlib_stored_block_decoder zsbd_checker u_zsbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the zlib stored-block decoder
// Builds zlib streams from stored blocks, some well formed and some broken,
// and sends them one byte per request. A predictor tracks the expected
// payload bytes and final reports, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import zsbd_pkg::*;

  // Block types that the decoder rejects as unsupported.
  localparam logic [1:0] BTYPE_FIXED   = 2'd1;
  localparam logic [1:0] BTYPE_DYNAMIC = 2'd2;
  localparam logic [7:0] ZLIB_FIRST    = 8'h78;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  zlib_stored_block_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("zlib_stored_block_decoder test failed");
    $finish;
  end

  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          items_sent    = 0;
  int          error_count   = 0;
  out_item_t   expected_results[$];

  // Decoder state as predicted from the accepted bytes.
  logic [31:0] capacity;
  logic [3:0]  dec_phase;
  int unsigned dec_count;
  logic [7:0]  hdr_byte;
  logic [15:0] block_len;
  logic [15:0] block_left;
  logic        last_block;
  logic [15:0] adler_a;
  logic [15:0] adler_b;
  logic [31:0] trailer_word;
  logic [31:0] produced;
  logic [2:0]  error_code;
  logic        error_seen;

  // Stream under construction and its running checksum.
  logic [7:0]  stream_q[$];
  logic [15:0] gen_a;
  logic [15:0] gen_b;

  task automatic report(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic clear_decoder();
    dec_phase    = PH_HDR0;
    dec_count    = 0;
    hdr_byte     = '0;
    block_len    = '0;
    block_left   = '0;
    last_block   = 1'b0;
    adler_a      = 16'd1;
    adler_b      = '0;
    trailer_word = '0;
    produced     = '0;
    error_code   = ST_OK;
    error_seen   = 1'b0;
  endtask

  task automatic set_error(input logic [2:0] code);
    error_seen = 1'b1;
    error_code = code;
  endtask

  task automatic end_block();
    dec_phase = last_block ? PH_TRAILER : PH_BLKHDR;
    dec_count = 0;
  endtask

  // Advance the predicted decoder by one stream byte and form its result.
  task automatic decode_byte(input logic [7:0] b, input logic eos,
                             output logic has_result, output out_item_t res);
    logic        emit;
    logic [15:0] hdr;
    logic [1:0]  btype;
    logic [15:0] nlen;
    logic [32:0] need;
    int unsigned sum;
    emit = 1'b0;
    if (!error_seen) begin
      case (dec_phase)
        PH_HDR0: begin
          hdr_byte  = b;
          dec_phase = PH_HDR1;
        end
        PH_HDR1: begin
          hdr = {hdr_byte, b};
          if ((hdr % 31) != 0 || hdr_byte[3:0] != ZLIB_CM ||
              hdr_byte[7:4] != ZLIB_CINFO || b[5])
            set_error(ST_HEADER);
          else
            dec_phase = PH_BLKHDR;
        end
        PH_BLKHDR: begin
          last_block = b[0];
          btype = b[2:1];
          if (btype == BTYPE_STORED) begin
            dec_phase = PH_LEN;
            dec_count = 0;
          end else if (btype == BTYPE_BAD) begin
            set_error(ST_BADTYPE);
          end else begin
            set_error(ST_HUFFMAN);
          end
        end
        PH_LEN: begin
          // LEN low, LEN high, NLEN low, then NLEN high closes the check.
          if (dec_count == 0) begin
            block_len = {8'h00, b};
            dec_count++;
          end else if (dec_count == 1) begin
            block_len[15:8] = b;
            dec_count++;
          end else if (dec_count == 2) begin
            hdr_byte = b;
            dec_count++;
          end else begin
            nlen = {b, hdr_byte};
            need = produced + block_len;
            if (block_len != ~nlen) begin
              set_error(ST_LEN);
            end else if (need > capacity) begin
              set_error(ST_OVERFLOW);
            end else begin
              block_left = block_len;
              if (block_left == 0) end_block();
              else dec_phase = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          sum = adler_a + b;
          adler_a = 16'(sum % ADLER_MOD);
          sum = adler_b + adler_a;
          adler_b = 16'(sum % ADLER_MOD);
          produced++;
          block_left--;
          if (block_left == 0) end_block();
        end
        PH_TRAILER: begin
          trailer_word = {trailer_word[23:0], b};
          dec_count++;
          if (dec_count == 4) begin
            dec_count = 0;
            if (trailer_word != {adler_b, adler_a}) set_error(ST_CHECKSUM);
            else dec_phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    has_result = emit || eos;
    res = '0;
    if (emit) begin
      res.payload_byte  = b;
      res.payload_valid = 1'b1;
    end
    if (eos) begin
      res.finished = 1'b1;
      if (error_seen) res.status = error_code;
      else if (dec_phase != PH_DONE) res.status = ST_TRUNCATED;
      else res.status = ST_OK;
      res.produced_length = produced;
      clear_decoder();
    end
  endtask

  // Predict on each accepted request and check each accepted result.
  always @(posedge clk) begin : monitor_blk
    logic      has_item;
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (in_valid && !in_stall) begin
        decode_byte(in_data.stream_byte, in_data.end_of_stream, has_item, want);
        if (has_item) expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report($sformatf("result with nothing expected: %h", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte %h, expected %h",
                             out_data.payload_byte, want.payload_byte));
          if (out_data.payload_valid !== want.payload_valid)
            report($sformatf("payload_valid %b, expected %b",
                             out_data.payload_valid, want.payload_valid));
          if (out_data.finished !== want.finished)
            report($sformatf("finished %b, expected %b",
                             out_data.finished, want.finished));
          if (out_data.status !== want.status)
            report($sformatf("status %0d, expected %0d",
                             out_data.status, want.status));
          if (out_data.produced_length !== want.produced_length)
            report($sformatf("produced_length %0d, expected %0d",
                             out_data.produced_length, want.produced_length));
        end
      end
    end
  end

  // Result side stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Send one byte, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{stream_byte: b, end_of_stream: eos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every expected result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] header_check_byte(input logic [7:0] first,
                                                   input logic [1:0] level,
                                                   input logic dict);
    logic [15:0] base;
    logic [4:0]  check;
    base  = {first, level, dict, 5'b0};
    check = 5'((31 - base % 31) % 31);
    return {level, dict, check};
  endfunction

  task automatic begin_stream();
    stream_q.delete();
    gen_a = 16'd1;
    gen_b = '0;
  endtask

  task automatic put_header();
    stream_q.push_back(ZLIB_FIRST);
    stream_q.push_back(header_check_byte(ZLIB_FIRST, 2'($urandom_range(3)), 1'b0));
  endtask

  // A block header, LEN, NLEN (optionally damaged) and the data bytes.
  // A fill value with bit 8 set gives constant data, otherwise it is random.
  task automatic put_block(input logic [15:0] len, input logic last,
                           input logic [1:0] btype, input logic [15:0] nlen_flip,
                           input logic [8:0] fill);
    logic [15:0] nlen;
    logic [7:0]  d;
    int unsigned sum;
    stream_q.push_back({5'($urandom_range(31)), btype, last});
    nlen = ~len ^ nlen_flip;
    stream_q.push_back(len[7:0]);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(nlen[7:0]);
    stream_q.push_back(nlen[15:8]);
    for (int i = 0; i < len; i++) begin
      d = fill[8] ? fill[7:0] : 8'($urandom);
      stream_q.push_back(d);
      sum = gen_a + d;
      gen_a = 16'(sum % ADLER_MOD);
      sum = gen_b + gen_a;
      gen_b = 16'(sum % ADLER_MOD);
    end
  endtask

  task automatic put_trailer(input logic corrupt);
    logic [31:0] w;
    w = {gen_b, gen_a};
    if (corrupt) w ^= 32'd1 << $urandom_range(31);
    for (int i = 3; i >= 0; i--) stream_q.push_back(w[8*i +: 8]);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // One random stream: mostly well formed, the rest broken or noise.
  task automatic random_stream();
    int          kind;
    int          nblk;
    int          bad_blk;
    int          pick;
    int          cut;
    logic [15:0] len;
    logic [1:0]  btype;
    logic [15:0] flip;
    kind = $urandom_range(99);
    begin_stream();
    if (kind >= 95) begin
      repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom));
    end else begin
      put_header();
      if (kind >= 74 && kind < 79) begin
        if ($urandom_range(1)) stream_q[0] = 8'($urandom);
        else stream_q[1] ^= 8'($urandom_range(1, 255));
      end
      nblk = $urandom_range(1, 3);
      bad_blk = $urandom_range(0, nblk - 1);
      for (int k = 0; k < nblk; k++) begin
        pick = $urandom_range(99);
        if (pick < 85) len = 16'($urandom_range(0, 12));
        else if (pick < 97) len = 16'($urandom_range(13, 60));
        else len = 16'($urandom_range(256, 300));
        btype = BTYPE_STORED;
        flip = '0;
        if (k == bad_blk && kind >= 63 && kind < 69) flip = 16'($urandom_range(1, 65535));
        if (k == bad_blk && kind >= 69 && kind < 74) btype = 2'($urandom_range(1, 3));
        put_block(len, k == nblk - 1, btype, flip, 9'h000);
      end
      put_trailer(kind >= 55 && kind < 63);
      if (kind >= 89) repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom));
      if (kind >= 79 && kind < 89) begin
        cut = $urandom_range(1, stream_q.size() - 1);
        stream_q = stream_q[0:cut-1];
      end
    end
    send_stream();
  endtask

  // Header checks: each rule broken alone, plus an end on the first byte.
  task automatic test_headers();
    send_byte(ZLIB_FIRST, 1'b1);
    send_byte(ZLIB_FIRST, 1'b0);
    send_byte(header_check_byte(ZLIB_FIRST, 2'd0, 1'b0) ^ 8'h01, 1'b1);
    send_byte(8'h79, 1'b0);
    send_byte(header_check_byte(8'h79, 2'd2, 1'b0), 1'b1);
    send_byte(8'h68, 1'b0);
    send_byte(header_check_byte(8'h68, 2'd1, 1'b0), 1'b1);
    // A dictionary request is refused; the bytes after it give no payload.
    send_byte(ZLIB_FIRST, 1'b0);
    send_byte(header_check_byte(ZLIB_FIRST, 2'd3, 1'b1), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_block_types();
    begin_stream();
    put_header();
    put_block(16'd2, 1'b1, BTYPE_FIXED, 16'h0000, 9'h000);
    send_stream();
    begin_stream();
    put_header();
    put_block(16'd1, 1'b0, BTYPE_DYNAMIC, 16'h0000, 9'h000);
    send_stream();
    begin_stream();
    put_header();
    put_block(16'd0, 1'b1, BTYPE_BAD, 16'h0000, 9'h000);
    send_stream();
  endtask

  task automatic test_stored_blocks();
    // Empty final block with the initial checksum as trailer.
    begin_stream();
    put_header();
    put_block(16'd0, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b0);
    send_stream();
    // Data bytes at both extremes across several blocks.
    begin_stream();
    put_header();
    put_block(16'd1, 1'b0, BTYPE_STORED, 16'h0000, 9'h100);
    put_block(16'd1, 1'b0, BTYPE_STORED, 16'h0000, 9'h1FF);
    put_block(16'd3, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b0);
    send_stream();
    // NLEN that is not the complement of LEN.
    begin_stream();
    put_header();
    put_block(16'd3, 1'b1, BTYPE_STORED, 16'h8000, 9'h000);
    put_trailer(1'b0);
    send_stream();
    // Trailer that does not match the checksum.
    begin_stream();
    put_header();
    put_block(16'd2, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b1);
    send_stream();
    // Stream ending on a data byte, which still goes out with the report.
    begin_stream();
    put_header();
    put_block(16'd3, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b0);
    stream_q = stream_q[0:8];
    send_stream();
    // Stream ending inside the trailer.
    begin_stream();
    put_header();
    put_block(16'd2, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b0);
    stream_q.pop_back();
    send_stream();
    // Bytes after a good trailer are ignored.
    begin_stream();
    put_header();
    put_block(16'd2, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b0);
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h00);
    send_stream();
  endtask

  // Capacity limits, including a capacity of one byte and an exact fit.
  task automatic test_capacity();
    write_capacity(32'd1);
    begin_stream();
    put_header();
    put_block(16'd1, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b0);
    send_stream();
    begin_stream();
    put_header();
    put_block(16'd1, 1'b0, BTYPE_STORED, 16'h0000, 9'h000);
    put_block(16'd1, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b0);
    send_stream();
    write_capacity(32'd2);
    begin_stream();
    put_header();
    put_block(16'd2, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b0);
    send_stream();
    begin_stream();
    put_header();
    put_block(16'd3, 1'b1, BTYPE_STORED, 16'h0000, 9'h000);
    put_trailer(1'b0);
    send_stream();
    write_capacity(32'h7FFF_FFFF);
    random_stream();
    write_capacity(CAPACITY_RST);
  endtask

  // Random streams under each idling pattern, then under small capacities.
  task automatic test_random();
    int idle_set[4];
    int stall_set[4];
    int goal;
    idle_set  = '{0, 52, 0, 32};
    stall_set = '{0, 0, 52, 32};
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      in_idle_pct   = idle_set[p];
      out_stall_pct = stall_set[p];
      goal = items_sent + 20;
      while (items_sent < goal) random_stream();
    end
    for (int k = 0; k < 2; k++) begin
      write_capacity(32'($urandom_range(1, 40)));
      random_stream();
    end
    write_capacity(CAPACITY_RST);
  endtask

  initial begin
    capacity = CAPACITY_RST;
    clear_decoder();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct   = 32;
    out_stall_pct = 32;
    test_headers();
    test_block_types();
    test_stored_blocks();
    test_capacity();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("zlib_stored_block_decoder test passed");
    end else begin
      $display("zlib_stored_block_decoder test failed");
    end
    $finish;
  end

endmodule
